@@ sv/amt_pkg.sv @@
// amt_pkg: shared types and constants for the alarm match table.
// Used by alarm_match_table and its testbench; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package amt_pkg;

    localparam int ENTRIES_DEF      = 16;
    localparam int MINUTES_PER_HOUR = 60;
    localparam int KEY_W            = 11;
    localparam logic [KEY_W-1:0] NO_KEY = 11'd1440;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    localparam logic ST_FIRED = 1'b0;
    localparam logic ST_FULL  = 1'b1;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] alarm_id;
        logic [4:0] alarm_hour;
        logic [5:0] alarm_minute;
        logic       alarm_once;
        logic [4:0] now_hour;
        logic [5:0] now_minute;
    } amt_req_t;

    typedef struct packed {
        logic       status;
        logic [7:0] fired_id;
        logic       last_of_run;
    } amt_res_t;

    typedef struct packed {
        logic [7:0] ident;
        logic [4:0] hour;
        logic [5:0] minute;
        logic       single;
    } amt_entry_t;

endpackage

`default_nettype wire

@@ sv/alarm_match_table.sv @@
// alarm_match_table: ordered alarm table with add, remove by id and minute tick.
// Depends on amt_pkg and amt_ram (table storage).
//
//  channel | ports                    | direction | payload
//  --------+--------------------------+-----------+-----------
//  request | s_valid s_ready s_data   | in        | amt_req_t
//  result  | m_valid m_ready m_data   | out       | amt_res_t
//
// One request at a time. Remove compacts the table in one walk over the RAM port.
// Tick walks the table for matches, plus a compaction walk when a once alarm fired;
// each walk moves one table entry a cycle over the RAM port, except while stalled.
// Reset clears count and last key; table contents need no clearing.
// A full result register holds the match walk until m_ready.
`timescale 1ns / 1ps
`default_nettype none

module alarm_match_table
    import amt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire amt_req_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output amt_res_t      m_data
);

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ENT_W = $bits(amt_entry_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_REJECT,
        S_SCAN,
        S_FLUSH,
        S_COMPACT
    } state_t;

    state_t           state_reg;
    amt_req_t         req_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] rd_idx_reg;
    logic [CNT_W-1:0] keep_reg;
    logic             ev_valid_reg;
    logic             pend_valid_reg;
    logic [7:0]       pend_id_reg;
    logic             any_once_reg;
    logic             by_id_reg;
    logic [7:0]       once_ids_reg [ENTRIES];
    logic [CNT_W-1:0] once_cnt_reg;
    logic [KEY_W-1:0] key_reg;
    logic             m_valid_reg;
    amt_res_t         m_data_reg;

    amt_entry_t       rd_entry;
    logic [ENT_W-1:0] rd_bits;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    amt_entry_t       ram_wdata;
    logic             ram_re;

    logic [KEY_W-1:0] tick_key;
    logic             out_free;
    logic             more;
    logic             walk_done;
    logic             match;
    logic             stall;
    logic             once_hit;
    logic             drop;
    logic             res_load;
    amt_entry_t       new_entry;

    assign rd_entry = amt_entry_t'(rd_bits);
    assign tick_key = KEY_W'(req_reg.now_hour) * KEY_W'(MINUTES_PER_HOUR)
                    + KEY_W'(req_reg.now_minute);
    assign out_free  = !m_valid_reg || m_ready;
    assign more      = rd_idx_reg < count_reg;
    assign walk_done = !ev_valid_reg && !more;
    assign match     = ev_valid_reg && (rd_entry.hour == req_reg.now_hour)
                    && (rd_entry.minute == req_reg.now_minute);
    assign stall     = match && pend_valid_reg && !out_free;
    assign drop      = by_id_reg ? (rd_entry.ident == req_reg.alarm_id) : once_hit;
    assign res_load  = ((state_reg == S_REJECT) && out_free)
                    || ((state_reg == S_SCAN) && match && pend_valid_reg && !stall)
                    || ((state_reg == S_FLUSH) && pend_valid_reg && out_free);

    // ids of fired once alarms, compared in parallel during compaction
    always_comb begin
        once_hit = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            if ((CNT_W'(i) < once_cnt_reg) && (once_ids_reg[i] == rd_entry.ident)) begin
                once_hit = 1'b1;
            end
        end
    end

    always_comb begin
        new_entry.ident  = req_reg.alarm_id;
        new_entry.hour   = req_reg.alarm_hour;
        new_entry.minute = req_reg.alarm_minute;
        new_entry.single = req_reg.alarm_once;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = count_reg[IDX_W-1:0];
        ram_wdata = new_entry;
        ram_re    = 1'b0;
        unique case (state_reg)
            S_DISPATCH: begin
                ram_we = (req_reg.command == CMD_ADD) && (count_reg < CNT_W'(ENTRIES));
            end
            S_SCAN: begin
                ram_re = !stall && more;
            end
            S_COMPACT: begin
                ram_re    = more;
                ram_we    = ev_valid_reg && !drop;
                ram_waddr = keep_reg[IDX_W-1:0];
                ram_wdata = rd_entry;
            end
            default: begin
            end
        endcase
    end

    amt_ram #(
        .WIDTH(ENT_W),
        .DEPTH(ENTRIES)
    ) u_table (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ENT_W'(ram_wdata)),
        .re   (ram_re),
        .raddr(rd_idx_reg[IDX_W-1:0]),
        .rdata(rd_bits)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            rd_idx_reg     <= '0;
            keep_reg       <= '0;
            ev_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            any_once_reg   <= 1'b0;
            by_id_reg      <= 1'b0;
            once_cnt_reg   <= '0;
            key_reg        <= NO_KEY;
            m_valid_reg    <= 1'b0;
        end else begin
            m_valid_reg <= res_load || (m_valid_reg && !m_ready);
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        req_reg   <= s_data;
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    priority if (req_reg.command == CMD_ADD) begin
                        if (count_reg < CNT_W'(ENTRIES)) begin
                            count_reg <= count_reg + CNT_W'(1);
                            state_reg <= S_IDLE;
                        end else begin
                            state_reg <= S_REJECT;
                        end
                    end else if (req_reg.command == CMD_REMOVE) begin
                        by_id_reg    <= 1'b1;
                        rd_idx_reg   <= '0;
                        keep_reg     <= '0;
                        ev_valid_reg <= 1'b0;
                        state_reg    <= S_COMPACT;
                    end else if (req_reg.command == CMD_TICK && tick_key != key_reg) begin
                        key_reg        <= tick_key;
                        once_cnt_reg   <= '0;
                        any_once_reg   <= 1'b0;
                        pend_valid_reg <= 1'b0;
                        rd_idx_reg     <= '0;
                        ev_valid_reg   <= 1'b0;
                        state_reg      <= S_SCAN;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_REJECT: begin
                    if (out_free) begin
                        m_data_reg.status      <= ST_FULL;
                        m_data_reg.fired_id    <= req_reg.alarm_id;
                        m_data_reg.last_of_run <= 1'b1;
                        state_reg              <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    if (!stall) begin
                        ev_valid_reg <= more;
                        if (more) begin
                            rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                        end
                        if (match) begin
                            if (pend_valid_reg) begin
                                m_data_reg.status      <= ST_FIRED;
                                m_data_reg.fired_id    <= pend_id_reg;
                                m_data_reg.last_of_run <= 1'b0;
                            end
                            pend_valid_reg <= 1'b1;
                            pend_id_reg    <= rd_entry.ident;
                            if (rd_entry.single) begin
                                once_ids_reg[once_cnt_reg[IDX_W-1:0]] <= rd_entry.ident;
                                once_cnt_reg <= once_cnt_reg + CNT_W'(1);
                                any_once_reg <= 1'b1;
                            end
                        end
                        if (walk_done) begin
                            state_reg <= S_FLUSH;
                        end
                    end
                end
                S_FLUSH: begin
                    if (!pend_valid_reg || out_free) begin
                        if (pend_valid_reg) begin
                            m_data_reg.status      <= ST_FIRED;
                            m_data_reg.fired_id    <= pend_id_reg;
                            m_data_reg.last_of_run <= 1'b1;
                        end
                        pend_valid_reg <= 1'b0;
                        by_id_reg      <= 1'b0;
                        rd_idx_reg     <= '0;
                        keep_reg       <= '0;
                        ev_valid_reg   <= 1'b0;
                        state_reg      <= any_once_reg ? S_COMPACT : S_IDLE;
                    end
                end
                S_COMPACT: begin
                    ev_valid_reg <= more;
                    if (more) begin
                        rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                    end
                    if (ev_valid_reg && !drop) begin
                        keep_reg <= keep_reg + CNT_W'(1);
                    end
                    if (walk_done) begin
                        count_reg <= keep_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(ENTRIES))
        else $error("entry count beyond table size");

    a_pend_scope: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> (state_reg == S_SCAN || state_reg == S_FLUSH))
        else $error("pending result outside a tick walk");

    a_keep_behind: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_COMPACT) |-> (keep_reg <= rd_idx_reg))
        else $error("compaction write ahead of read");

    a_reject_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == ST_FULL) |-> m_data.last_of_run)
        else $error("reject result not marked last");

endmodule

`default_nettype wire

@@ sv/amt_ram.sv @@
// amt_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module amt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
